// File: rtl/core/cplr_pkg.sv
// Package for the CRC packet link receiver: item types, protocol codes, CRC helpers.
package cplr_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  packet_byte;
    logic [11:0] read_index;
  } req_item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        is_read;
    logic [4:0]  log_value;
    logic [11:0] log_fill;
    logic        last;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // Register index of the only config register
  localparam logic REG_TIMEOUT = 1'b0;

  // Command field (top three bits of a command byte)
  localparam logic [2:0] CMD_RESET  = 3'b000;
  localparam logic [2:0] CMD_LOG    = 3'b001;
  localparam logic [2:0] CMD_ACK    = 3'b010;
  localparam logic [2:0] CMD_REPEAT = 3'b111;

  // Coded bytes that go out on the link
  localparam logic [7:0] CODE_RESET  = 8'h00;
  localparam logic [7:0] CODE_ACK    = 8'h5F;
  localparam logic [7:0] CODE_REPEAT = 8'hE1;
  localparam logic [7:0] MARK_CHECK11 = 8'hAA;
  localparam logic [7:0] MARK_CHECK3  = 8'hBB;

  // Generator 0x35 without its top bit
  localparam logic [4:0] GEN_LOW = 5'h15;

  localparam int RSP_SLOTS = 4;

  // One polynomial step on a 6-bit partial remainder
  function automatic logic [4:0] crc_reduce(input logic [5:0] r);
    crc_reduce = r[4:0] ^ (r[5] ? GEN_LOW : 5'h00);
  endfunction

  // Byte with its own 3-bit CRC filled into the low five bits
  function automatic logic [7:0] code3(input logic [7:0] m);
    logic [4:0] r;
    r = crc_reduce({m[7:5], 3'b000});
    r = crc_reduce({r, 1'b0});
    r = crc_reduce({r, 1'b0});
    code3 = m | {3'b000, r};
  endfunction

  // 5-bit CRC over held byte, command bits and five zeros
  function automatic logic [4:0] crc11(input logic [7:0] held, input logic [7:0] cmd);
    logic [4:0] r;
    logic [9:0] stream;
    r = crc_reduce(held[7:2]);
    stream = {held[1:0], cmd[7:5], 5'b00000};
    for (int i = 9; i >= 0; i--) begin
      r = crc_reduce({r, stream[i]});
    end
    crc11 = r;
  endfunction

endpackage

// File: rtl/core/cplr_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module cplr_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/crc_packet_link_receiver_unit.sv
// Top level of the CRC packet link receiver: input stage, protocol logic, result queue.
// Flow: an accepted item is registered in the input stage and processed there once the
//   result queue has room for three results; its results are written into the queue and
//   offered in order. Further results follow one per cycle while rsp_stall is low.
// Throughput: one item per cycle while each item yields at most one result and the
//   output is not stalled; the four-slot result queue and the single output port limit it.
// Reset: synchronous, active high; clears protocol state, timers, log position and
//   queue. Log contents stay undefined until written; there is no clearing pass.
module crc_packet_link_receiver_unit
  import cplr_pkg::*;
#(
  parameter int LOG_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  req_item_t   req,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_item_t   rsp,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(LOG_DEPTH);

  // ---------------------------------------------------------------- config
  logic [15:0] timeout_ticks;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'h0000, timeout_ticks} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 16'h0000;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------- state
  logic [7:0]    held_packet, held_packet_next;
  logic          held_valid, held_valid_next;
  logic [15:0]   ack_count, ack_count_next;
  logic          ack_running, ack_running_next;
  logic [15:0]   cmd_count, cmd_count_next;
  logic          cmd_running, cmd_running_next;
  logic [AW-1:0] write_position, write_position_next;

  // input stage
  logic      s1_valid;
  req_item_t s1_item;
  logic      fire;
  logic      accept;

  // result queue
  rsp_item_t  q [RSP_SLOTS];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       pop;
  logic [2:0] count_after_pop;
  logic       room;

  // log memory path
  logic          log_wr;
  logic [AW-1:0] rd_addr;
  logic [4:0]    ram_rdata;
  logic          rd_in_range;
  logic          byp_hit;
  logic [4:0]    byp_data;
  logic [31:0]   idx_wide;

  // results built for the item in the input stage
  rsp_item_t res [3];
  logic [1:0] n_res;

  logic [31:0] wp_wide, wpn_wide;

  assign pop             = rsp_valid && !rsp_stall;
  assign count_after_pop = count - {2'b00, pop};
  assign room            = count_after_pop <= 3'd1;   // space for three results
  assign fire            = s1_valid && room;
  assign req_stall       = s1_valid && !room;
  assign accept          = req_valid && !req_stall;

  assign idx_wide = 32'(req.read_index);
  assign rd_addr  = idx_wide[AW-1:0];
  assign wp_wide  = 32'(write_position);
  assign wpn_wide = 32'(write_position_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Read address is presented at acceptance; a write landing on the same
  // edge and address is forwarded, since the RAM reads old data.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item     <= req;
      rd_in_range <= idx_wide < 32'(LOG_DEPTH);
      byp_hit     <= fire && log_wr && (write_position == rd_addr);
      byp_data    <= held_packet[4:0];
    end
  end

  cplr_ram #(
    .WIDTH (5),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (fire && log_wr),
    .waddr (write_position),
    .wdata (held_packet[4:0]),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  function automatic rsp_item_t mk(input logic [7:0] tx, input logic rd,
                                   input logic [4:0] val, input logic [11:0] fill);
    rsp_item_t r;
    r.tx_byte   = tx;
    r.is_read   = rd;
    r.log_value = val;
    r.log_fill  = fill;
    r.last      = 1'b0;
    mk = r;
  endfunction

  // ---------------------------------------------------------------- protocol
  always_comb begin
    logic [7:0]  p;
    logic [11:0] fill;
    logic [15:0] ack_dec, cmd_dec;
    logic        ack_fire, cmd_fire;
    logic        start_ack;
    logic [4:0]  rd_val;

    p    = s1_item.packet_byte;
    fill = wp_wide[11:0];
    ack_dec = ack_count - 16'd1;
    cmd_dec = cmd_count - 16'd1;
    ack_fire  = 1'b0;
    cmd_fire  = 1'b0;
    start_ack = 1'b0;
    rd_val    = 5'h00;

    held_packet_next    = held_packet;
    held_valid_next     = held_valid;
    ack_count_next      = ack_count;
    ack_running_next    = ack_running;
    cmd_count_next      = cmd_count;
    cmd_running_next    = cmd_running;
    write_position_next = write_position;
    log_wr              = 1'b0;
    n_res               = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = mk(8'h00, 1'b0, 5'h00, fill);
    end

    case (action_t'(s1_item.action))
      ACT_BYTE: begin
        res[0] = mk(p, 1'b0, 5'h00, fill);   // echo
        n_res  = 2'd1;
        if (p[7]) begin
          held_packet_next = p;
          held_valid_next  = 1'b1;
          if (timeout_ticks != 16'h0000) begin
            cmd_count_next   = timeout_ticks;
            cmd_running_next = 1'b1;
          end
        end else begin
          cmd_running_next = 1'b0;
          if (held_valid) begin
            if (crc11(held_packet, p) == p[4:0]) begin
              if (p[7:5] == CMD_LOG) begin
                log_wr = 1'b1;
                write_position_next = (write_position == AW'(LOG_DEPTH - 1)) ?
                                      '0 : write_position + 1'b1;
                held_valid_next = 1'b0;
                res[1] = mk(CODE_ACK, 1'b0, 5'h00, wpn_wide[11:0]);
                n_res  = 2'd2;
              end else begin
                held_packet_next = CODE_RESET;
                held_valid_next  = 1'b1;
                start_ack        = 1'b1;
                res[1] = mk(CODE_RESET, 1'b0, 5'h00, fill);
                n_res  = 2'd2;
              end
            end else begin
              held_valid_next = 1'b0;
              res[1] = mk(MARK_CHECK11, 1'b0, 5'h00, fill);
              res[2] = mk(CODE_REPEAT, 1'b0, 5'h00, fill);
              n_res  = 2'd3;
            end
          end else if (code3(p) == p) begin
            if (p[7:5] == CMD_ACK) begin
              ack_running_next = 1'b0;
            end else if (p[7:5] != CMD_REPEAT) begin
              // repeat with nothing held sends only the echo
              held_packet_next = CODE_RESET;
              held_valid_next  = 1'b1;
              start_ack        = 1'b1;
              res[1] = mk(CODE_RESET, 1'b0, 5'h00, fill);
              n_res  = 2'd2;
            end
          end else begin
            res[1] = mk(MARK_CHECK3, 1'b0, 5'h00, fill);
            res[2] = mk(CODE_REPEAT, 1'b0, 5'h00, fill);
            n_res  = 2'd3;
          end
        end
      end
      ACT_TICK: begin
        if (ack_running) begin
          ack_count_next = ack_dec;
          if (ack_dec == 16'h0000) begin
            ack_running_next = 1'b0;
            ack_fire         = 1'b1;
          end
        end
        if (cmd_running) begin
          cmd_count_next = cmd_dec;
          if (cmd_dec == 16'h0000) begin
            cmd_running_next = 1'b0;
            cmd_fire         = 1'b1;
          end
        end
        if (ack_fire) begin
          held_packet_next = 8'h00;
          held_valid_next  = 1'b0;
          res[0] = mk(CODE_REPEAT, 1'b0, 5'h00, fill);
          n_res  = 2'd1;
        end
        if (cmd_fire) begin
          held_packet_next = CODE_RESET;
          held_valid_next  = 1'b1;
          start_ack        = 1'b1;
          res[ack_fire ? 1 : 0] = mk(CODE_RESET, 1'b0, 5'h00, fill);
          n_res  = ack_fire ? 2'd2 : 2'd1;
        end
      end
      ACT_READ: begin
        if (rd_in_range) begin
          rd_val = byp_hit ? byp_data : ram_rdata;
        end
        res[0] = mk(8'h00, 1'b1, rd_val, fill);
        n_res  = 2'd1;
      end
      default: begin
        n_res = 2'd0;   // unused action: no result
      end
    endcase

    // acknowledge-wait start overrides any countdown from this tick
    if (start_ack && timeout_ticks != 16'h0000) begin
      ack_count_next   = timeout_ticks;
      ack_running_next = 1'b1;
    end

    if (n_res != 2'd0) begin
      res[n_res - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_packet    <= 8'h00;
      held_valid     <= 1'b0;
      ack_count      <= 16'h0000;
      ack_running    <= 1'b0;
      cmd_count      <= 16'h0000;
      cmd_running    <= 1'b0;
      write_position <= '0;
    end else if (fire) begin
      held_packet    <= held_packet_next;
      held_valid     <= held_valid_next;
      ack_count      <= ack_count_next;
      ack_running    <= ack_running_next;
      cmd_count      <= cmd_count_next;
      cmd_running    <= cmd_running_next;
      write_position <= write_position_next;
    end
  end

  // ---------------------------------------------------------------- result queue
  assign rsp_valid = count != 3'd0;
  assign rsp       = q[rptr];

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < n_res) begin
          q[2'(wptr + 2'(k))] <= res[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (fire) begin
        wptr <= wptr + n_res;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count_after_pop + (fire ? {1'b0, n_res} : 3'd0);
    end
  end

  // ---------------------------------------------------------------- checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(RSP_SLOTS))
    else $error("result queue overflow");

  a_ack_timer_live: assert property (@(posedge clk) disable iff (rst)
    ack_running |-> ack_count != 16'h0000)
    else $error("ack timer running at zero");

  a_cmd_timer_live: assert property (@(posedge clk) disable iff (rst)
    cmd_running |-> cmd_count != 16'h0000)
    else $error("command timer running at zero");

  a_log_advance: assert property (@(posedge clk) disable iff (rst)
    fire && log_wr |=> write_position != $past(write_position))
    else $error("log position did not advance on write");

  a_data_held: assert property (@(posedge clk) disable iff (rst)
    fire && s1_item.action == ACT_BYTE && s1_item.packet_byte[7] |=> held_valid)
    else $error("data packet not held");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for crc_packet_link_receiver_unit with a link-protocol scoreboard.
module tb;
  import cplr_pkg::*;

  localparam int LOG_DEPTH = 4096;
  // timeout_ticks sits at byte address 4 * REG_TIMEOUT
  localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
  // $error lines beyond this many are counted but not printed
  localparam int REPORT_CAP = 100;

  // Remainder of a 16-bit message divided by x^5 + x^4 + x^2 + 1, MSB first
  function automatic logic [4:0] crc5_rem(input logic [15:0] msg);
    logic [5:0] r;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      r = {r[4:0], msg[i]};
      if (r[5]) r = r ^ 6'h35;
    end
    return r[4:0];
  endfunction

  // Command byte carrying its own 3-bit code in the low bits
  function automatic logic [7:0] with_code3(input logic [7:0] m);
    return m | {3'b000, crc5_rem({8'h00, m[7:5], 5'b00000})};
  endfunction

  // Command that passes the long check against a held packet
  function automatic logic [7:0] cmd_for(input logic [7:0] pkt, input logic [2:0] op);
    return {op, crc5_rem({pkt, op, 5'b00000})};
  endfunction

  // Tracks link protocol state and the replies the block still owes
  class link_reply_board;
    rsp_item_t   replies_due[$];
    rsp_item_t   batch[$];
    logic [15:0] timeout;
    logic [7:0]  held;
    bit          held_ok;
    logic [15:0] ack_cnt;
    logic [15:0] cmd_cnt;
    bit          ack_run;
    bit          cmd_run;
    logic [4:0]  log_mem [LOG_DEPTH];
    logic [11:0] wpos;
    int          entries_written;
    int          log_writes;
    int          accepted;
    int          checked;
    int          errors;

    function new();
      timeout = '0;
      held = '0;
      held_ok = 0;
      ack_cnt = '0;
      cmd_cnt = '0;
      ack_run = 0;
      cmd_run = 0;
      wpos = '0;
      entries_written = 0;
      log_writes = 0;
      accepted = 0;
      checked = 0;
      errors = 0;
    endfunction

    function void push_reply(input logic [7:0] tx, input bit rd, input logic [4:0] v);
      rsp_item_t e;
      e.tx_byte = tx;
      e.is_read = rd;
      e.log_value = v;
      e.log_fill = wpos;
      e.last = 1'b0;
      batch.push_back(e);
    endfunction

    function void start_ack_wait();
      if (timeout != 0) begin
        ack_cnt = timeout;
        ack_run = 1;
      end
    endfunction

    function void start_cmd_wait();
      if (timeout != 0) begin
        cmd_cnt = timeout;
        cmd_run = 1;
      end
    endfunction

    function void sensor_reset();
      held = with_code3({CMD_RESET, 5'b00000});
      held_ok = 1;
      push_reply(held, 1'b0, 5'd0);
      start_ack_wait();
    endfunction

    function void take_byte(input logic [7:0] p);
      push_reply(p, 1'b0, 5'd0);
      if (p[7]) begin
        held = p;
        held_ok = 1;
        start_cmd_wait();
      end else begin
        cmd_run = 0;
        if (held_ok) begin
          if (crc5_rem({held, p[7:5], 5'b00000}) == p[4:0]) begin
            if (p[7:5] == CMD_LOG) begin
              log_mem[wpos] = held[4:0];
              wpos = wpos + 1'b1;
              log_writes++;
              if (entries_written < LOG_DEPTH) entries_written++;
              held_ok = 0;
              push_reply(with_code3({CMD_ACK, 5'b00000}), 1'b0, 5'd0);
            end else begin
              sensor_reset();
            end
          end else begin
            held_ok = 0;
            push_reply(MARK_CHECK11, 1'b0, 5'd0);
            push_reply(with_code3({CMD_REPEAT, 5'b00000}), 1'b0, 5'd0);
          end
        end else if (with_code3(p) == p) begin
          if (p[7:5] == CMD_ACK) begin
            held_ok = 0;
            ack_run = 0;
          end else if (p[7:5] != CMD_REPEAT) begin
            sensor_reset();
          end
          // repeat request lands here only with nothing held: echo alone
        end else begin
          push_reply(MARK_CHECK3, 1'b0, 5'd0);
          push_reply(with_code3({CMD_REPEAT, 5'b00000}), 1'b0, 5'd0);
        end
      end
    endfunction

    function void take_tick();
      bit ack_fire;
      bit cmd_fire;
      ack_fire = 0;
      cmd_fire = 0;
      if (ack_run) begin
        ack_cnt = ack_cnt - 1'b1;
        if (ack_cnt == 0) begin
          ack_run = 0;
          ack_fire = 1;
        end
      end
      if (cmd_run) begin
        cmd_cnt = cmd_cnt - 1'b1;
        if (cmd_cnt == 0) begin
          cmd_run = 0;
          cmd_fire = 1;
        end
      end
      // ack-wait reports before cmd-wait when both expire together
      if (ack_fire) begin
        push_reply(with_code3({CMD_REPEAT, 5'b00000}), 1'b0, 5'd0);
        held = '0;
        held_ok = 0;
      end
      if (cmd_fire) sensor_reset();
    endfunction

    // Called once per accepted item
    function void take_request(input req_item_t it);
      rsp_item_t e;
      batch.delete();
      accepted++;
      case (action_t'(it.action))
        ACT_BYTE: take_byte(it.packet_byte);
        ACT_TICK: take_tick();
        ACT_READ: push_reply(8'h00, 1'b1, log_mem[it.read_index]);
        default: ;
      endcase
      if (batch.size() > 0) begin
        e = batch.pop_back();
        e.last = 1'b1;
        batch.push_back(e);
      end
      foreach (batch[i]) replies_due.push_back(batch[i]);
    endfunction

    function void field_check(input string name, input logic [11:0] want,
                              input logic [11:0] got);
      if (want !== got) begin
        if (errors < REPORT_CAP) $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Called once per accepted result
    function void match_reply(input rsp_item_t got);
      rsp_item_t want;
      checked++;
      if (replies_due.size() == 0) begin
        if (errors < REPORT_CAP)
          $error("result with nothing expected: tx_byte %h is_read %b", got.tx_byte, got.is_read);
        errors++;
      end else begin
        want = replies_due.pop_front();
        field_check("tx_byte", want.tx_byte, got.tx_byte);
        field_check("is_read", want.is_read, got.is_read);
        field_check("log_value", want.log_value, got.log_value);
        field_check("log_fill", want.log_fill, got.log_fill);
        field_check("last", want.last, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_item_t   req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_item_t   rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  link_reply_board sb;

  // Idle odds per cycle, in percent, for the sender and the receiver
  int gap_pct = 30;
  int stall_pct = 30;
  // Main process bumps hold_ask; the receiver answers with a long hold-off
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int sent = 0;

  crc_packet_link_receiver_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // Receiver: check each accepted result, then pick the stall for the next cycle.
  // A requested hold-off is counted down here so it runs independent of the sender.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.match_reply(rsp);
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = 200;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("crc_packet_link_receiver_unit: mismatch");
    $finish;
  end

  // Offer one item, optionally after random idle cycles; returns at the accepting edge.
  // Valid stays high on return so a following item goes out back to back.
  task automatic send(input req_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.take_request(it);
    sent++;
  endtask

  task automatic release_req();
    req_valid <= 1'b0;
  endtask

  function automatic req_item_t mk(input action_t a, input logic [7:0] b,
                                   input logic [11:0] idx);
    req_item_t r;
    r.action = a;
    r.packet_byte = b;
    r.read_index = idx;
    return r;
  endfunction

  task automatic byte_item(input logic [7:0] b);
    send(mk(ACT_BYTE, b, 12'($urandom)));
  endtask

  task automatic tick_item();
    send(mk(ACT_TICK, 8'($urandom), 12'($urandom)));
  endtask

  task automatic read_item(input logic [11:0] idx);
    send(mk(ACT_READ, 8'($urandom), idx));
  endtask

  // Two-phase APB transfer; pready may in principle extend the access phase
  task automatic reg_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register writes only with the block drained. Ticks that fire nothing leave no
  // trace in the queue, so the task also waits after the queue drains to cover any item still in flight.
  task automatic set_timeout(input logic [15:0] v);
    logic [31:0] rd;
    release_req();
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    reg_access(1'b1, TIMEOUT_ADDR, {16'h0000, v}, rd);
    sb.timeout = v;
    @(posedge clk);
    reg_access(1'b0, TIMEOUT_ADDR, 32'h0, rd);
    if (rd[15:0] !== v) begin
      $error("timeout_ticks readback: expected %h, got %h", v, rd[15:0]);
      sb.errors++;
    end
  endtask

  // One random step: packet + command pairs with random content in 45% of steps, the rest
  // ticks, stray commands, log reads, unused actions and raw noise bytes.
  task automatic random_step();
    logic [7:0] pkt;
    logic [2:0] op;
    int k;
    k = $urandom_range(99);
    if (k < 45) begin
      pkt = 8'h80 | 8'($urandom);
      byte_item(pkt);
      // ticks between packet and command can expire the command wait
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) tick_item();
      k = $urandom_range(99);
      if (k < 60) begin
        byte_item(cmd_for(pkt, CMD_LOG));
      end else if (k < 75) begin
        // non-log command with a good long CRC: reset, ack or 011
        op = {1'b0, 2'($urandom)};
        if (op == CMD_LOG) op = CMD_RESET;
        byte_item(cmd_for(pkt, op));
      end else begin
        byte_item({1'b0, 7'($urandom)});
      end
    end else if (k < 60) begin
      tick_item();
    end else if (k < 72) begin
      if ($urandom_range(1))
        byte_item(with_code3({1'b0, 2'($urandom), 5'b00000}) | {3'b000, 5'($urandom)});
      else
        byte_item({1'b0, 7'($urandom)});
    end else if (k < 85 && sb.entries_written > 0) begin
      read_item(12'($urandom_range(sb.entries_written - 1)));
    end else if (k < 90) begin
      send(mk(ACT_NONE, 8'($urandom), 12'($urandom)));
    end else begin
      byte_item(8'($urandom));
    end
  endtask

  initial begin
    int unsigned tmo_steps[6];
    logic [7:0] pkt;
    int target;

    tmo_steps = '{3, 65535, 1, 0, 2, 5};
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ---- directed: every command path with timers off ----
    set_timeout(16'd0);
    byte_item(8'h00);                              // reset command, no packet held
    byte_item(cmd_for(8'h00, CMD_LOG));            // log against the reset's held 0x00
    byte_item(8'hFF);                              // data packet, all ones
    byte_item(cmd_for(8'hFF, CMD_LOG));            // log 0x1F
    byte_item(8'h80);
    byte_item(cmd_for(8'h80, CMD_ACK));            // passing non-log command: sensor reset
    byte_item(8'h9A);
    byte_item(cmd_for(8'h9A, CMD_LOG) ^ 8'h01);    // long CRC fails: marker + repeat
    byte_item(with_code3({CMD_ACK, 5'b00000}));    // ack with nothing held
    byte_item(8'h41);                              // own 3-bit code fails
    byte_item(8'h7F);                              // code bits covered by extra ones: passes
    tick_item();                                   // no timer running: silent
    send(mk(ACT_NONE, 8'hFF, 12'hFFF));            // unused action: silent
    read_item(12'd0);
    read_item(12'd1);

    // timeout of one tick: command wait expires, then the ack wait it starts
    set_timeout(16'd1);
    byte_item(8'h85);
    tick_item();
    tick_item();

    // both timers expiring on the same tick
    set_timeout(16'd2);
    byte_item(8'h00);
    byte_item(8'h90);
    tick_item();
    tick_item();

    // ---- back-to-back log writes and two reads, no idling on either side, then random reads ----
    set_timeout(16'd7);
    gap_pct = 0;
    stall_pct = 0;
    repeat (30) begin
      pkt = 8'h80 | 8'($urandom);
      byte_item(pkt);
      byte_item(cmd_for(pkt, CMD_LOG));
    end
    read_item(12'd0);
    read_item(12'(sb.entries_written - 1));
    gap_pct = 30;
    stall_pct = 30;
    repeat (10) read_item(12'($urandom_range(sb.entries_written - 1)));

    // ---- random phases across timeout settings ----
    foreach (tmo_steps[i]) begin
      set_timeout(tmo_steps[i][15:0]);
      target = sent + 50;
      if (i == 1) begin
        // receiver holds off while items keep coming: queue fills, input stalls
        hold_ask++;
        gap_pct = 0;
        repeat (40) random_step();
        gap_pct = 30;
      end
      if (i == 3) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      while (sent < target) random_step();
      gap_pct = 30;
      stall_pct = 30;
    end

    release_req();
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d items and %0d results; %0d log entries written.",
             sb.accepted, sb.checked, sb.log_writes);
    $display("Timeouts from 0 to 65535, both timers expiring, output hold-off, log reads.");
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("crc_packet_link_receiver_unit: match");
    end else begin
      $display("crc_packet_link_receiver_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/cplr_pkg.sv
rtl/core/cplr_ram.sv
rtl/core/crc_packet_link_receiver_unit.sv
dv/tb.sv
